FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Clocked assertion helpers shared by the swipe gesture detector modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of aclk outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

FILE: src/swg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types, codes and the gesture step function of the swipe detector.
// ----------------------------------------------------------------------------
package swg_pkg;

    // widths
    localparam int DIST_BITS_DEFAULT = 16;
    localparam int THR_BITS          = 16;
    localparam int STATUS_BITS       = 8;
    localparam int TIME_BITS         = 32;
    localparam int OUT_DATA_W        = 8;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 16;

    // register reset values
    localparam logic [THR_BITS-1:0] NEAR_THRESHOLD_RESET = 16'd500;
    localparam logic [THR_BITS-1:0] TIMEOUT_MS_RESET     = 16'd1200;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS     = 8'd1;

    // item kinds
    localparam logic KIND_EVALUATE = 1'b0;
    localparam logic KIND_TIMEOUT  = 1'b1;

    // sensor status codes
    localparam logic [STATUS_BITS-1:0] STATUS_VALID     = 8'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ALT_VALID = 8'd7;

    // all three step marks set
    localparam logic [2:0] MARKS_ALL = 3'b111;

    typedef enum logic [2:0] {
        GEST_NONE       = 3'd0,
        GEST_DOWN_UP    = 3'd1,
        GEST_UP_DOWN    = 3'd2,
        GEST_LEFT_RIGHT = 3'd3,
        GEST_RIGHT_LEFT = 3'd4
    } gesture_t;

    // result item, gesture in the low bits
    typedef struct packed {
        logic     marks_cleared;
        gesture_t gesture;
    } result_t;

    // apply the three ordered step checks of one gesture to its marks
    // step2_on_mark2: step two is blocked by its own mark instead of step three
    function automatic logic [2:0] step_marks(
        input logic [2:0] marks,
        input logic       cond1,
        input logic       cond2,
        input logic       cond3,
        input logic       step2_on_mark2
    );
        logic [2:0] m1;
        logic [2:0] m2;
        logic [2:0] m3;
        logic       blocked;
        m1 = marks;
        if (cond1 && !marks[1] && !marks[2]) begin
            m1[0] = 1'b1;
        end
        blocked = step2_on_mark2 ? m1[1] : m1[2];
        m2 = m1;
        if (cond2 && !blocked && m1[0]) begin
            m2[1] = 1'b1;
        end
        m3 = m2;
        if (cond3 && m2[1] && m2[0]) begin
            m3[2] = 1'b1;
        end
        return m3;
    endfunction

endpackage

FILE: src/swg_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_in_stage
// Input register: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module swg_in_stage #(
    parameter int ITEM_W = 104,
    parameter int PORT_W = 104
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PORT_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              advance,
    output logic              item_valid,
    output logic [ITEM_W-1:0] item_data,
    output logic              item_kind
);

    logic              valid_reg;
    logic              valid_next;
    logic [ITEM_W-1:0] data_reg;
    logic              kind_reg;
    logic              load;

    // take a new request when empty or when the held one moves on
    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_tdata[ITEM_W-1:0];
            kind_reg <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;
    assign item_kind  = kind_reg;

endmodule

FILE: src/swg_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// swg_core
// Gesture marks, timeout timer and result logic for one request per cycle while advance is high.
// ----------------------------------------------------------------------------
module swg_core #(
    parameter int DIST_BITS = swg_pkg::DIST_BITS_DEFAULT,
    parameter int ITEM_W    = 3 * DIST_BITS + 56
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          item_kind,
    input  logic [ITEM_W-1:0]             item_data,
    input  logic [swg_pkg::THR_BITS-1:0]  near_threshold,
    input  logic [swg_pkg::THR_BITS-1:0]  timeout_ms,
    output swg_pkg::result_t              result
);

    localparam int SB     = swg_pkg::STATUS_BITS;
    localparam int TB     = swg_pkg::TIME_BITS;
    localparam int CMP_W  = (DIST_BITS > swg_pkg::THR_BITS) ? DIST_BITS : swg_pkg::THR_BITS;
    localparam int LS_LO  = 3 * DIST_BITS;
    localparam int CS_LO  = LS_LO + SB;
    localparam int RS_LO  = CS_LO + SB;
    localparam int NOW_LO = RS_LO + SB;

    logic [2:0]    du_marks_reg, du_marks_next;
    logic [2:0]    ud_marks_reg, ud_marks_next;
    logic [2:0]    lr_marks_reg, lr_marks_next;
    logic [2:0]    rl_marks_reg, rl_marks_next;
    logic          armed_reg, armed_next;
    logic [TB-1:0] start_reg, start_next;

    logic [DIST_BITS-1:0] l_dist, c_dist, r_dist;
    logic [SB-1:0]        l_stat, c_stat, r_stat;
    logic [TB-1:0]        now;
    logic [CMP_W-1:0]     thr;
    logic                 l_near, c_near, r_near, l_far, c_far, r_far;
    logic                 l_ok, c_ok, r_ok, l_ok7, c_ok7, r_ok7;
    logic [2:0]           du_eval, ud_eval, lr_eval, rl_eval;
    logic [TB-1:0]        start_eff;
    logic [TB-1:0]        elapsed;
    logic                 expired;

    // field unpacking
    assign l_dist = item_data[DIST_BITS-1:0];
    assign c_dist = item_data[2*DIST_BITS-1:DIST_BITS];
    assign r_dist = item_data[3*DIST_BITS-1:2*DIST_BITS];
    assign l_stat = item_data[LS_LO+SB-1:LS_LO];
    assign c_stat = item_data[CS_LO+SB-1:CS_LO];
    assign r_stat = item_data[RS_LO+SB-1:RS_LO];
    assign now    = item_data[NOW_LO+TB-1:NOW_LO];

    // near / far against the threshold, equal is neither
    assign thr    = CMP_W'(near_threshold);
    assign l_near = CMP_W'(l_dist) < thr;
    assign c_near = CMP_W'(c_dist) < thr;
    assign r_near = CMP_W'(r_dist) < thr;
    assign l_far  = CMP_W'(l_dist) > thr;
    assign c_far  = CMP_W'(c_dist) > thr;
    assign r_far  = CMP_W'(r_dist) > thr;

    // status acceptance
    assign l_ok  = l_stat == swg_pkg::STATUS_VALID;
    assign c_ok  = c_stat == swg_pkg::STATUS_VALID;
    assign r_ok  = r_stat == swg_pkg::STATUS_VALID;
    assign l_ok7 = l_ok || (l_stat == swg_pkg::STATUS_ALT_VALID);
    assign c_ok7 = c_ok || (c_stat == swg_pkg::STATUS_ALT_VALID);
    assign r_ok7 = r_ok || (r_stat == swg_pkg::STATUS_ALT_VALID);

    // ordered step checks of each gesture
    assign du_eval = swg_pkg::step_marks(du_marks_reg,
        l_near && l_ok7 && c_far && r_far,
        r_near && r_ok7 && c_far,
        c_near && c_ok7, 1'b1);
    assign ud_eval = swg_pkg::step_marks(ud_marks_reg,
        c_near && c_ok && l_far && r_far,
        r_near && r_ok && l_far,
        l_near && l_ok, 1'b0);
    assign lr_eval = swg_pkg::step_marks(lr_marks_reg,
        l_near && l_ok && c_far && r_far,
        c_near && c_ok && r_far,
        r_near && r_ok, 1'b0);
    assign rl_eval = swg_pkg::step_marks(rl_marks_reg,
        r_near && r_ok && c_far && l_far,
        c_near && c_ok && l_far,
        l_near && l_ok, 1'b0);

    // timer: arm on first check, expire on wrapping difference
    assign start_eff = armed_reg ? start_reg : now;
    assign elapsed   = now - start_eff;
    assign expired   = elapsed > TB'(timeout_ms);

    // next state and result
    always_comb begin
        du_marks_next        = du_marks_reg;
        ud_marks_next        = ud_marks_reg;
        lr_marks_next        = lr_marks_reg;
        rl_marks_next        = rl_marks_reg;
        armed_next           = armed_reg;
        start_next           = start_reg;
        result.gesture       = swg_pkg::GEST_NONE;
        result.marks_cleared = 1'b0;
        if (item_kind == swg_pkg::KIND_EVALUATE) begin
            du_marks_next = du_eval;
            ud_marks_next = ud_eval;
            lr_marks_next = lr_eval;
            rl_marks_next = rl_eval;
            if (du_eval == swg_pkg::MARKS_ALL) begin
                result.gesture = swg_pkg::GEST_DOWN_UP;
            end else if (ud_eval == swg_pkg::MARKS_ALL) begin
                result.gesture = swg_pkg::GEST_UP_DOWN;
            end else if (lr_eval == swg_pkg::MARKS_ALL) begin
                result.gesture = swg_pkg::GEST_LEFT_RIGHT;
            end else if (rl_eval == swg_pkg::MARKS_ALL) begin
                result.gesture = swg_pkg::GEST_RIGHT_LEFT;
            end
        end else begin
            start_next = start_eff;
            if (expired) begin
                armed_next           = 1'b0;
                du_marks_next        = '0;
                ud_marks_next        = '0;
                lr_marks_next        = '0;
                rl_marks_next        = '0;
                result.marks_cleared = 1'b1;
            end else begin
                armed_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            du_marks_reg <= '0;
            ud_marks_reg <= '0;
            lr_marks_reg <= '0;
            rl_marks_reg <= '0;
            armed_reg    <= 1'b0;
            start_reg    <= '0;
        end else if (advance) begin
            du_marks_reg <= du_marks_next;
            ud_marks_reg <= ud_marks_next;
            lr_marks_reg <= lr_marks_next;
            rl_marks_reg <= rl_marks_next;
            armed_reg    <= armed_next;
            start_reg    <= start_next;
        end
    end

    // a clearing timeout leaves every mark clear and the timer disarmed
    `ASSERT_CLK(a_clear_empties, advance && result.marks_cleared |=> du_marks_reg == 3'b000 && ud_marks_reg == 3'b000 && lr_marks_reg == 3'b000 && rl_marks_reg == 3'b000 && !armed_reg, "timeout clear left marks or timer set")
    // evaluate requests never report a clear
    `ASSERT_NEVER(a_eval_no_clear, advance && item_kind == swg_pkg::KIND_EVALUATE && result.marks_cleared, "evaluate request reported a clear")
    // down-up and right-left marks are sticky across evaluate requests
    `ASSERT_CLK(a_marks_sticky, advance && item_kind == swg_pkg::KIND_EVALUATE |=> (du_marks_reg & $past(du_marks_reg)) == $past(du_marks_reg) && (rl_marks_reg & $past(rl_marks_reg)) == $past(rl_marks_reg), "evaluate request dropped a mark")
    // a timeout check that does not clear leaves the timer armed
    `ASSERT_CLK(a_timer_arms, advance && item_kind == swg_pkg::KIND_TIMEOUT && !result.marks_cleared |=> armed_reg, "timeout check did not arm the timer")

endmodule

FILE: src/swg_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module swg_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  swg_pkg::result_t                 result,
    output logic                             space,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swg_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic             valid_reg;
    logic             valid_next;
    swg_pkg::result_t result_reg;

    // room for a new result when empty or when the held one is taken
    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = swg_pkg::OUT_DATA_W'(result_reg);

endmodule

FILE: src/swipe_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_gesture_detector
// Swipe gesture detection on three proximity sensors with a mark timeout.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns exactly one result per request, in
// order. A request is held in the input register and is evaluated against
// the gesture marks and timer on its way into the result register, which
// drives m_tdata; the mark and timer update is combinational logic, which
// sets the rate of one request per cycle. A result held by a low m_tready
// holds off the next request.
// tuser selects the request kind (0 evaluate readings, 1 timeout check).
// Configuration writes (index 0 near threshold, 1 timeout in ms) are taken at
// any time but should only be issued while no request is in flight.
module swipe_gesture_detector #(
    parameter int DIST_BITS = swg_pkg::DIST_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: left_distance, center_distance, right_distance, left_status,
    //        center_status, right_status, now_ms, zero fill
    input  logic [((3 * DIST_BITS + 3 * swg_pkg::STATUS_BITS + swg_pkg::TIME_BITS + 7) / 8)
                  * 8 - 1:0]                  s_tdata,
    // tuser: kind
    input  logic                              s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: gesture[2:0], marks_cleared[3], zero fill
    output logic [swg_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [swg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ITEM_W   = 3 * DIST_BITS + 3 * swg_pkg::STATUS_BITS + swg_pkg::TIME_BITS;
    localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;

    logic [swg_pkg::THR_BITS-1:0] near_threshold_reg;
    logic [swg_pkg::THR_BITS-1:0] timeout_ms_reg;
    logic                         item_valid;
    logic [ITEM_W-1:0]            item_data;
    logic                         item_kind;
    logic                         out_space;
    logic                         advance;
    swg_pkg::result_t             result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_threshold_reg <= swg_pkg::NEAR_THRESHOLD_RESET;
            timeout_ms_reg     <= swg_pkg::TIMEOUT_MS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                swg_pkg::REG_NEAR_THRESHOLD: near_threshold_reg <= cfg_data;
                swg_pkg::REG_TIMEOUT_MS:     timeout_ms_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // move the held request into the result register
    assign advance = item_valid && out_space;

    swg_in_stage #(
        .ITEM_W (ITEM_W),
        .PORT_W (S_DATA_W)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_kind  (item_kind)
    );

    swg_core #(
        .DIST_BITS (DIST_BITS),
        .ITEM_W    (ITEM_W)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .item_kind      (item_kind),
        .item_data      (item_data),
        .near_threshold (near_threshold_reg),
        .timeout_ms     (timeout_ms_reg),
        .result         (result)
    );

    swg_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: verif/swipe_gesture_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_gesture_detector_test
// Self-checking bench for the swipe gesture detector. A queue-fed driver sends
// evaluate and timeout-check requests in random bursts, and a monitor under a
// rotating stall pattern compares every result with an in-bench gesture and
// timer tracker. A directed opening walks each swipe, the priority order, the
// status 7 rule, distances on the threshold and time wrap. Random phases then
// run under extreme and random threshold and timeout settings.
// ----------------------------------------------------------------------------
module swipe_gesture_detector_test;

    localparam int DIST_W      = swg_pkg::DIST_BITS_DEFAULT;
    localparam int STAT_W      = swg_pkg::STATUS_BITS;
    localparam int TIME_W      = swg_pkg::TIME_BITS;
    localparam int THR_W       = swg_pkg::THR_BITS;
    localparam int IDX_W       = swg_pkg::CFG_INDEX_W;
    localparam int CFG_W       = swg_pkg::CFG_DATA_W;
    localparam int OUT_W       = swg_pkg::OUT_DATA_W;
    localparam int S_DATA_W    = ((3 * DIST_W + 3 * STAT_W + TIME_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;

    // register indexes that select no register
    localparam logic [IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [IDX_W-1:0] REG_TOP   = 8'hFF;

    // sensor positions
    localparam int SENSOR_LEFT   = 0;
    localparam int SENSOR_CENTER = 1;
    localparam int SENSOR_RIGHT  = 2;
    localparam int SENSOR_NONE   = 3;

    typedef struct packed {
        logic              kind;
        logic [DIST_W-1:0] l_dist;
        logic [DIST_W-1:0] c_dist;
        logic [DIST_W-1:0] r_dist;
        logic [STAT_W-1:0] l_stat;
        logic [STAT_W-1:0] c_stat;
        logic [STAT_W-1:0] r_stat;
        logic [TIME_W-1:0] now_ms;
    } request_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    // tracked copy of the block's registers and gesture state
    logic [THR_W-1:0]  thr_reg = swg_pkg::NEAR_THRESHOLD_RESET;
    logic [THR_W-1:0]  tmo_reg = swg_pkg::TIMEOUT_MS_RESET;
    logic [2:0]        du_marks = '0;
    logic [2:0]        ud_marks = '0;
    logic [2:0]        lr_marks = '0;
    logic [2:0]        rl_marks = '0;
    logic              timer_on = 1'b0;
    logic [TIME_W-1:0] timer_start = '0;

    request_t          pending[$];
    swg_pkg::result_t  results_due[$];

    // idle shaping, set per phase
    int          gap_max = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    logic [3:0]  stall_pos = '0;

    int gap_left = 0;
    int burst_left = 0;
    request_t on_wire;
    int quiet_cycles = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int directed_items = 0;
    int settings_run = 0;
    int clears_seen = 0;
    int gestures_seen [5] = '{0, 0, 0, 0, 0};

    swipe_gesture_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // one gesture's three ordered steps; self_block: step two held off by its own mark
    function automatic logic [2:0] advance(input logic [2:0] marks, input logic c1,
                                           input logic c2, input logic c3,
                                           input logic self_block);
        logic [2:0] m;
        m = marks;
        if (c1 && !m[1] && !m[2]) begin
            m[0] = 1'b1;
        end
        if (c2 && m[0] && !(self_block ? m[1] : m[2])) begin
            m[1] = 1'b1;
        end
        if (c3 && m[0] && m[1]) begin
            m[2] = 1'b1;
        end
        return m;
    endfunction

    // expected result of one request, updating the tracked state
    function automatic swg_pkg::result_t detect_gesture(input request_t q);
        swg_pkg::result_t res;
        logic ln, cn, rn, lf, cf, rf;
        logic lv, cv, rv, lw, cw, rw;
        logic [TIME_W-1:0] elapsed;
        res.gesture = swg_pkg::GEST_NONE;
        res.marks_cleared = 1'b0;
        if (q.kind == swg_pkg::KIND_EVALUATE) begin
            ln = q.l_dist < thr_reg;
            cn = q.c_dist < thr_reg;
            rn = q.r_dist < thr_reg;
            lf = q.l_dist > thr_reg;
            cf = q.c_dist > thr_reg;
            rf = q.r_dist > thr_reg;
            lv = q.l_stat == swg_pkg::STATUS_VALID;
            cv = q.c_stat == swg_pkg::STATUS_VALID;
            rv = q.r_stat == swg_pkg::STATUS_VALID;
            lw = lv || q.l_stat == swg_pkg::STATUS_ALT_VALID;
            cw = cv || q.c_stat == swg_pkg::STATUS_ALT_VALID;
            rw = rv || q.r_stat == swg_pkg::STATUS_ALT_VALID;
            du_marks = advance(du_marks, ln && lw && cf && rf, rn && rw && cf, cn && cw, 1'b1);
            ud_marks = advance(ud_marks, cn && cv && lf && rf, rn && rv && lf, ln && lv, 1'b0);
            lr_marks = advance(lr_marks, ln && lv && cf && rf, cn && cv && rf, rn && rv, 1'b0);
            rl_marks = advance(rl_marks, rn && rv && cf && lf, cn && cv && lf, ln && lv, 1'b0);
            if (du_marks == swg_pkg::MARKS_ALL) begin
                res.gesture = swg_pkg::GEST_DOWN_UP;
            end else if (ud_marks == swg_pkg::MARKS_ALL) begin
                res.gesture = swg_pkg::GEST_UP_DOWN;
            end else if (lr_marks == swg_pkg::MARKS_ALL) begin
                res.gesture = swg_pkg::GEST_LEFT_RIGHT;
            end else if (rl_marks == swg_pkg::MARKS_ALL) begin
                res.gesture = swg_pkg::GEST_RIGHT_LEFT;
            end
        end else begin
            if (!timer_on) begin
                timer_on = 1'b1;
                timer_start = q.now_ms;
            end
            elapsed = q.now_ms - timer_start;
            if (elapsed > TIME_W'(tmo_reg)) begin
                timer_on = 1'b0;
                du_marks = '0;
                ud_marks = '0;
                lr_marks = '0;
                rl_marks = '0;
                res.marks_cleared = 1'b1;
            end
        end
        return res;
    endfunction

    // tdata layout, lowest bits first
    function automatic logic [S_DATA_W-1:0] pack_request(input request_t q);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[3*DIST_W+3*STAT_W+TIME_W-1:0] =
            {q.now_ms, q.r_stat, q.c_stat, q.l_stat, q.r_dist, q.c_dist, q.l_dist};
        return d;
    endfunction

    function automatic logic [DIST_W-1:0] rand_dist();
        return DIST_W'($urandom());
    endfunction

    function automatic logic [STAT_W-1:0] rand_stat();
        return STAT_W'($urandom());
    endfunction

    function automatic request_t eval_item(input logic [DIST_W-1:0] l,
                                           input logic [DIST_W-1:0] c,
                                           input logic [DIST_W-1:0] r,
                                           input logic [STAT_W-1:0] ls,
                                           input logic [STAT_W-1:0] cs,
                                           input logic [STAT_W-1:0] rs);
        request_t q;
        q.kind = swg_pkg::KIND_EVALUATE;
        q.l_dist = l;
        q.c_dist = c;
        q.r_dist = r;
        q.l_stat = ls;
        q.c_stat = cs;
        q.r_stat = rs;
        q.now_ms = $urandom();
        return q;
    endfunction

    // sensor fields are random on timer checks, the block ignores them
    function automatic request_t timer_check(input logic [TIME_W-1:0] now);
        request_t q;
        q = eval_item(rand_dist(), rand_dist(), rand_dist(),
                      rand_stat(), rand_stat(), rand_stat());
        q.kind = swg_pkg::KIND_TIMEOUT;
        q.now_ms = now;
        return q;
    endfunction

    function automatic logic [STAT_W-1:0] pick_status();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) begin
            return swg_pkg::STATUS_VALID;
        end else if (r < 85) begin
            return swg_pkg::STATUS_ALT_VALID;
        end
        return rand_stat();
    endfunction

    function automatic logic [DIST_W-1:0] near_dist();
        if (thr_reg == 0) begin
            return '0;
        end
        return DIST_W'($urandom_range(int'(thr_reg) - 1, 0));
    endfunction

    function automatic logic [DIST_W-1:0] far_dist();
        if (thr_reg == '1) begin
            return '1;
        end
        return DIST_W'($urandom_range(65535, int'(thr_reg) + 1));
    endfunction

    // readings with one sensor near (or none), now and then one on the threshold
    function automatic request_t reading(input int near_at, input logic [STAT_W-1:0] st);
        logic [DIST_W-1:0] d [3];
        logic [STAT_W-1:0] s [3];
        for (int i = 0; i < 3; i++) begin
            d[i] = (i == near_at) ? near_dist() : far_dist();
            if ($urandom_range(15, 0) == 0) begin
                d[i] = thr_reg;
            end
            s[i] = (i == near_at) ? st : pick_status();
        end
        return eval_item(d[0], d[1], d[2], s[0], s[1], s[2]);
    endfunction

    // sensor that is near at each step of a swipe
    function automatic int swipe_pose(input int g, input int k);
        case (g)
            0: return (k == 0) ? SENSOR_LEFT : (k == 1) ? SENSOR_RIGHT : SENSOR_CENTER;
            1: return (k == 0) ? SENSOR_CENTER : (k == 1) ? SENSOR_RIGHT : SENSOR_LEFT;
            2: return (k == 0) ? SENSOR_LEFT : (k == 1) ? SENSOR_CENTER : SENSOR_RIGHT;
            default: return (k == 0) ? SENSOR_RIGHT : (k == 1) ? SENSOR_CENTER : SENSOR_LEFT;
        endcase
    endfunction

    // random phase: mostly swipe sequences, plus timer checks and noise
    task automatic fill_random(input int count);
        int added;
        int pick;
        int g;
        int spot;
        int reps;
        int r;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(99, 0);
            if (pick < 14) begin
                r = $urandom_range(9, 0);
                if (r < 5) begin
                    clock_ms = clock_ms + $urandom_range(int'(tmo_reg) / 4 + 2, 0);
                end else if (r < 8) begin
                    clock_ms = clock_ms + TIME_W'(tmo_reg) + $urandom_range(2, 0) - 32'd1;
                end else begin
                    clock_ms = $urandom();
                end
                pending.push_back(timer_check(clock_ms));
                added++;
            end else if (pick < 24) begin
                pending.push_back(eval_item(rand_dist(), rand_dist(), rand_dist(),
                                            rand_stat(), rand_stat(), rand_stat()));
                added++;
            end else begin
                g = $urandom_range(3, 0);
                for (int k = 0; k < 3; k++) begin
                    spot = swipe_pose(g, k);
                    // broken sequence: wrong or missing sensor
                    if ($urandom_range(7, 0) == 0) begin
                        spot = int'($urandom_range(SENSOR_NONE, SENSOR_LEFT));
                    end
                    reps = $urandom_range(2, 1);
                    repeat (reps) begin
                        pending.push_back(reading(spot, pick_status()));
                        added++;
                    end
                end
            end
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == swg_pkg::REG_NEAR_THRESHOLD) begin
            thr_reg = val;
        end else if (idx == swg_pkg::REG_TIMEOUT_MS) begin
            tmo_reg = val;
        end
    endtask

    // wait for every request to be sent and answered, then let the pipe settle
    task automatic drain();
        do @(posedge aclk); while (pending.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic shape_idling();
        gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        ready_mask = ($urandom_range(3, 0) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge aclk) begin : driver
        logic send;
        send = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                results_due.push_back(detect_gesture(on_wire));
                items_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending.size() > 0) begin
                on_wire = pending.pop_front();
                s_tdata <= pack_request(on_wire);
                s_tuser <= on_wire.kind;
                send = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(24, 1);
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
                end
            end
            s_tvalid <= send;
        end
    end

    // result monitor with rotating stall pattern
    always @(posedge aclk) begin : monitor
        swg_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_pos <= '0;
        end else begin
            m_tready <= ready_mask[stall_pos];
            stall_pos <= stall_pos + 4'd1;
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result 0x%02h with no request pending", m_tdata));
                end else begin
                    want = results_due.pop_front();
                    if (m_tdata[2:0] !== want.gesture) begin
                        report_mismatch($sformatf("gesture %0d, expected %0d",
                                                  m_tdata[2:0], want.gesture));
                    end
                    if (m_tdata[3] !== want.marks_cleared) begin
                        report_mismatch($sformatf("marks_cleared %0b, expected %0b",
                                                  m_tdata[3], want.marks_cleared));
                    end
                    if (want.gesture != swg_pkg::GEST_NONE) begin
                        gestures_seen[want.gesture]++;
                    end
                    if (want.marks_cleared) begin
                        clears_seen++;
                    end
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [DIST_W-1:0] far_v;
        logic [DIST_W-1:0] near_v;
        logic [THR_W-1:0]  new_thr;
        logic [THR_W-1:0]  new_tmo;
        far_v = 16'd1000;
        near_v = 16'd100;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening at reset register values
        shape_idling();
        pending.push_back(eval_item(far_v, far_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        // down-up with the alternate status on left and center
        pending.push_back(eval_item(near_v, far_v, far_v, swg_pkg::STATUS_ALT_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(far_v, far_v, near_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(far_v, near_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_ALT_VALID, swg_pkg::STATUS_VALID));
        // complete marks stay and report again
        pending.push_back(eval_item(far_v, far_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        // arm, elapsed equal to timeout, then one past it
        pending.push_back(timer_check(32'd1000));
        pending.push_back(timer_check(32'd2200));
        pending.push_back(timer_check(32'd2201));
        // distance on the threshold is neither near nor far
        pending.push_back(eval_item(swg_pkg::NEAR_THRESHOLD_RESET, far_v, far_v,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID));
        // up-down
        pending.push_back(eval_item(far_v, near_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(far_v, far_v, near_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(near_v, far_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        // clear across a time wrap
        pending.push_back(timer_check(32'hFFFF_FF00));
        pending.push_back(timer_check(32'h0000_0400));
        // left-right, then up-down completes too and wins on priority
        pending.push_back(eval_item(near_v, far_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(far_v, near_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(far_v, far_v, near_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(near_v, far_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        // wrap right at the boundary
        pending.push_back(timer_check(32'hFFFF_FFFF));
        pending.push_back(timer_check(32'h0000_04AF));
        pending.push_back(timer_check(32'h0000_04B0));
        // right-left
        pending.push_back(eval_item(far_v, far_v, near_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(far_v, near_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(eval_item(near_v, far_v, far_v, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        // field extremes
        pending.push_back(eval_item('1, '1, '1, '1, '1, '1));
        pending.push_back(eval_item('0, '0, '0, swg_pkg::STATUS_VALID,
                                    swg_pkg::STATUS_VALID, swg_pkg::STATUS_VALID));
        pending.push_back(timer_check(32'h0000_0000));
        directed_items = pending.size();
        drain();

        // random phases under changing register settings
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    new_thr = '0;
                    new_tmo = '0;
                end
                1: begin
                    new_thr = '1;
                    new_tmo = '1;
                end
                2: begin
                    new_thr = 16'd1;
                    new_tmo = 16'd1;
                end
                3: begin
                    new_thr = 16'hFFFE;
                    new_tmo = THR_W'($urandom_range(3000, 0));
                end
                default: begin
                    new_thr = THR_W'($urandom_range(60000, 20));
                    new_tmo = THR_W'($urandom_range(3000, 0));
                end
            endcase
            write_reg(swg_pkg::REG_NEAR_THRESHOLD, new_thr);
            write_reg(swg_pkg::REG_TIMEOUT_MS, new_tmo);
            // writes to unused indexes must change nothing
            if (p == 2) begin
                write_reg(REG_SPARE, CFG_W'($urandom()));
            end else if (p == 5) begin
                write_reg(REG_TOP, CFG_W'($urandom()));
            end
            settings_run++;
            shape_idling();
            clock_ms = $urandom();
            fill_random((p < 4) ? 30 : 75);
            drain();
        end

        if (results_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        end
        $display("ran %0d requests (%0d directed) over %0d register settings, %0d results checked",
                 items_sent, directed_items, settings_run + 1, results_checked);
        $display("swipes reported: down-up %0d, up-down %0d, left-right %0d, right-left %0d; %s %0d",
                 gestures_seen[swg_pkg::GEST_DOWN_UP], gestures_seen[swg_pkg::GEST_UP_DOWN],
                 gestures_seen[swg_pkg::GEST_LEFT_RIGHT],
                 gestures_seen[swg_pkg::GEST_RIGHT_LEFT], "clears", clears_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/swg_pkg.sv
src/swg_in_stage.sv
src/swg_core.sv
src/swg_out_stage.sv
src/swipe_gesture_detector.sv
verif/swipe_gesture_detector_test.sv
